// File: rtl/pic_pkg.sv
// ----------------------------------------------------------------------------
// Priority interrupt controller package
// Request codes, status codes, register indexes and fixed constants shared by
// the controller.
// ----------------------------------------------------------------------------
package pic_pkg;

   localparam int unsigned SOURCE_ID_W = 16;
   localparam int unsigned SLOT_W      = 5;
   localparam int unsigned LEVEL_W     = 4;
   localparam int unsigned WORD_W      = 16;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [LEVEL_W-1:0]     LEVEL_TOP        = 4'hF;
   localparam logic [SOURCE_ID_W-1:0] NMI_VECTOR_RESET = 16'd11;

   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_RAISE  = 2'd1,
      FUNC_CHECK  = 2'd2,
      FUNC_ACCEPT = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_DUPLICATE = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_NMI_RISING_EDGE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NMI_VECTOR      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_SOURCE_ID   = 2'd2;

endpackage

// File: rtl/priority_interrupt_controller_core.sv
// ----------------------------------------------------------------------------
// Priority interrupt controller core
// Source table with packed priority nibbles, NMI edge detection and a
// sequential table scan for add, raise, check and accept requests.
// ----------------------------------------------------------------------------
// One request at a time. A request is taken when start is high and busy is
// low; its result shows on the rsp_ ports for exactly one cycle with rsp_valid
// high and must be taken then, as the receiver cannot stall the block. An add
// with an illegal id or slot, and a check that sees an NMI edge, answer in the
// cycle after start. Every other request walks the source table one entry
// per cycle through a single compare unit fed by the registered table read
// port. Busy drops in the cycle the result is shown, so the next request may
// start at once. No clearing pass is needed after reset.
module priority_interrupt_controller_core
   import pic_pkg::*;
#(
   parameter int unsigned MAX_SOURCES    = 32,
   parameter int unsigned PRIORITY_WORDS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_func,
   input  logic [SOURCE_ID_W-1:0] req_source_id,
   input  logic [SLOT_W-1:0]      req_slot,
   input  logic [LEVEL_W-1:0]     req_level,
   input  logic                   req_nmi_pin,
   input  logic [LEVEL_W-1:0]     req_cpu_mask,
   output logic                   rsp_valid,
   output logic [SOURCE_ID_W-1:0] rsp_chosen_source,
   output logic [LEVEL_W-1:0]     rsp_chosen_level,
   output logic [LEVEL_W-1:0]     rsp_new_mask,
   output logic [1:0]             rsp_status,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_wdata
);

   localparam int unsigned IDX_W  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
   localparam int unsigned CNT_W  = $clog2(MAX_SOURCES + 1);
   localparam int unsigned WIDX_W = (PRIORITY_WORDS > 1) ? $clog2(PRIORITY_WORDS) : 1;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // ---- helpers ------------------------------------------------------------
   function automatic logic slot_legal(input logic [SLOT_W-1:0] s);
      logic [7:0] w;
      w = {5'b0, s[SLOT_W-1:2]};
      return w < 8'(PRIORITY_WORDS);
   endfunction

   function automatic logic [WIDX_W-1:0] word_index(input logic [SLOT_W-1:0] s);
      logic [7:0] w;
      w = {5'b0, s[SLOT_W-1:2]};
      return w[WIDX_W-1:0];
   endfunction

   // ---- registers ----------------------------------------------------------
   state_type                           state_ff, state_in;
   func_type                            func_ff, func_in;
   logic [SOURCE_ID_W-1:0]              id_ff, id_in;
   logic [SLOT_W-1:0]                   slot_ff, slot_in;
   logic [LEVEL_W-1:0]                  level_ff, level_in;
   logic [LEVEL_W-1:0]                  mask_ff, mask_in;

   logic                                nmi_rising_ff, nmi_rising_in;
   logic [SOURCE_ID_W-1:0]              nmi_vector_ff, nmi_vector_in;
   logic [SOURCE_ID_W-1:0]              min_id_ff, min_id_in;

   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [MAX_SOURCES-1:0]              pending_ff, pending_in;
   logic [PRIORITY_WORDS-1:0][WORD_W-1:0] prio_ff, prio_in;
   logic                                last_nmi_ff, last_nmi_in;
   logic [LEVEL_W-1:0]                  held_ff, held_in;

   logic [CNT_W-1:0]                    scan_cnt_ff, scan_cnt_in;
   logic                                rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]                    rd_idx_ff, rd_idx_in;
   logic                                hit_ff, hit_in;
   logic [IDX_W-1:0]                    hit_idx_ff, hit_idx_in;
   logic [LEVEL_W-1:0]                  best_ff, best_in;
   logic [SOURCE_ID_W-1:0]              best_id_ff, best_id_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [SOURCE_ID_W-1:0]              rsp_chosen_ff, rsp_chosen_in;
   logic [LEVEL_W-1:0]                  rsp_level_ff, rsp_level_in;
   logic [LEVEL_W-1:0]                  rsp_mask_ff, rsp_mask_in;
   status_type                          rsp_status_ff, rsp_status_in;

   // ---- source table memory ------------------------------------------------
   logic [SOURCE_ID_W-1:0] id_mem   [MAX_SOURCES];
   logic [SLOT_W-1:0]      slot_mem [MAX_SOURCES];
   logic [SOURCE_ID_W-1:0] rd_id_ff;
   logic [SLOT_W-1:0]      rd_slot_ff;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_rd_addr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         id_mem[count_ff[IDX_W-1:0]]   <= id_ff;
         slot_mem[count_ff[IDX_W-1:0]] <= slot_ff;
      end
      rd_id_ff   <= id_mem[mem_rd_addr];
      rd_slot_ff <= slot_mem[mem_rd_addr];
   end

   // ---- level of the entry under evaluation --------------------------------
   logic [WORD_W-1:0]  scan_word;
   logic [LEVEL_W-1:0] scan_level;

   always_comb begin
      scan_word = prio_ff[word_index(rd_slot_ff)];
      case (rd_slot_ff[1:0])
         2'd0:    scan_level = scan_word[15:12];
         2'd1:    scan_level = scan_word[11:8];
         2'd2:    scan_level = scan_word[7:4];
         default: scan_level = scan_word[3:0];
      endcase
      if (!slot_legal(rd_slot_ff)) begin
         scan_level = '0;
      end
   end

   // ---- next state ---------------------------------------------------------
   logic nmi_edge;
   logic scan_done;

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      id_in         = id_ff;
      slot_in       = slot_ff;
      level_in      = level_ff;
      mask_in       = mask_ff;
      nmi_rising_in = nmi_rising_ff;
      nmi_vector_in = nmi_vector_ff;
      min_id_in     = min_id_ff;
      count_in      = count_ff;
      pending_in    = pending_ff;
      prio_in       = prio_ff;
      last_nmi_in   = last_nmi_ff;
      held_in       = held_ff;
      scan_cnt_in   = scan_cnt_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      best_in       = best_ff;
      best_id_in    = best_id_ff;
      rsp_valid_in  = 1'b0;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_rd_addr   = scan_cnt_ff[IDX_W-1:0];

      nmi_edge  = nmi_rising_ff ? (!last_nmi_ff && req_nmi_pin)
                                : (last_nmi_ff && !req_nmi_pin);
      scan_done = (scan_cnt_ff >= count_ff) && !rd_vld_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_NMI_RISING_EDGE: nmi_rising_in = csr_wdata[0];
            CSR_NMI_VECTOR:      nmi_vector_in = csr_wdata;
            CSR_MIN_SOURCE_ID:   min_id_in     = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in     = func_type'(req_func);
               id_in       = req_source_id;
               slot_in     = req_slot;
               level_in    = req_level;
               mask_in     = req_cpu_mask;
               scan_cnt_in = '0;
               hit_in      = 1'b0;
               hit_idx_in  = '0;
               best_in     = '0;
               best_id_in  = '0;
               state_in    = ST_SCAN;
               case (func_type'(req_func))
                  FUNC_ADD: begin
                     if (req_source_id < min_id_ff || !slot_legal(req_slot)) begin
                        state_in      = ST_IDLE;
                        rsp_valid_in  = 1'b1;
                        rsp_chosen_in = '0;
                        rsp_level_in  = held_ff;
                        rsp_mask_in   = '0;
                        rsp_status_in = STATUS_NOT_FOUND;
                     end
                  end
                  FUNC_CHECK: begin
                     last_nmi_in = req_nmi_pin;
                     if (nmi_edge) begin
                        state_in      = ST_IDLE;
                        held_in       = LEVEL_TOP;
                        rsp_valid_in  = 1'b1;
                        rsp_chosen_in = nmi_vector_ff;
                        rsp_level_in  = LEVEL_TOP;
                        rsp_mask_in   = '0;
                        rsp_status_in = STATUS_OK;
                     end
                  end
                  FUNC_ACCEPT: begin
                     // keep the held priority as the mask to hand back
                     level_in = held_ff;
                     held_in  = '0;
                  end
                  default: ;
               endcase
            end
         end

         ST_SCAN: begin
            // issue stage: read the next table entry
            if (scan_cnt_ff < count_ff) begin
               rd_vld_in   = 1'b1;
               rd_idx_in   = scan_cnt_ff[IDX_W-1:0];
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end

            // evaluate stage: first id match, best pending level above the mask
            if (rd_vld_ff) begin
               if (!hit_ff && rd_id_ff == id_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = rd_idx_ff;
               end
               if (pending_ff[rd_idx_ff] && scan_level > best_ff && scan_level > mask_ff) begin
                  best_in    = scan_level;
                  best_id_in = rd_id_ff;
               end
            end

            if (scan_done) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_chosen_in = '0;
               rsp_level_in  = held_ff;
               rsp_mask_in   = '0;
               rsp_status_in = STATUS_OK;
               case (func_ff)
                  FUNC_ADD: begin
                     if (hit_ff) begin
                        rsp_status_in = STATUS_DUPLICATE;
                     end else if (count_ff >= CNT_W'(MAX_SOURCES)) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        mem_we                           = 1'b1;
                        pending_in[count_ff[IDX_W-1:0]] = 1'b0;
                        count_in                         = count_ff + 1'b1;
                        case (slot_ff[1:0])
                           2'd0:    prio_in[word_index(slot_ff)][15:12] = level_ff;
                           2'd1:    prio_in[word_index(slot_ff)][11:8]  = level_ff;
                           2'd2:    prio_in[word_index(slot_ff)][7:4]   = level_ff;
                           default: prio_in[word_index(slot_ff)][3:0]   = level_ff;
                        endcase
                     end
                  end
                  FUNC_RAISE: begin
                     if (hit_ff) begin
                        pending_in[hit_idx_ff] = 1'b1;
                     end else begin
                        rsp_status_in = STATUS_NOT_FOUND;
                     end
                  end
                  FUNC_CHECK: begin
                     held_in       = best_ff;
                     rsp_chosen_in = best_id_ff;
                     rsp_level_in  = best_ff;
                  end
                  default: begin
                     rsp_mask_in = level_ff;
                     rsp_level_in = '0;
                     if (hit_ff) begin
                        pending_in[hit_idx_ff] = 1'b0;
                     end else begin
                        rsp_status_in = STATUS_NOT_FOUND;
                     end
                  end
               endcase
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // ---- state and registered outputs ---------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         nmi_rising_ff <= 1'b0;
         nmi_vector_ff <= NMI_VECTOR_RESET;
         min_id_ff     <= '0;
         count_ff      <= '0;
         pending_ff    <= '0;
         prio_ff       <= '0;
         last_nmi_ff   <= 1'b0;
         held_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         nmi_rising_ff <= nmi_rising_in;
         nmi_vector_ff <= nmi_vector_in;
         min_id_ff     <= min_id_in;
         count_ff      <= count_in;
         pending_ff    <= pending_in;
         prio_ff       <= prio_in;
         last_nmi_ff   <= last_nmi_in;
         held_ff       <= held_in;
         rd_vld_ff     <= rd_vld_in;
         hit_ff        <= hit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      func_ff       <= func_in;
      id_ff         <= id_in;
      slot_ff       <= slot_in;
      level_ff      <= level_in;
      mask_ff       <= mask_in;
      scan_cnt_ff   <= scan_cnt_in;
      rd_idx_ff     <= rd_idx_in;
      hit_idx_ff    <= hit_idx_in;
      best_ff       <= best_in;
      best_id_ff    <= best_id_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_source = rsp_chosen_ff;
   assign rsp_chosen_level  = rsp_level_ff;
   assign rsp_new_mask      = rsp_mask_ff;
   assign rsp_status        = rsp_status_ff;

   // ---- assertions ---------------------------------------------------------
   a_start_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither scanning nor answered");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SOURCES))
      else $error("table count beyond capacity");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_SCAN))
      else $error("table read outside a scan");

   a_hit_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && hit_ff) |-> (CNT_W'(hit_idx_ff) < count_ff))
      else $error("matched entry beyond the table fill");

   a_idle_response: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while still scanning");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Priority interrupt controller testbench
// Drives add, raise, check and accept requests into the controller core, first
// from a short directed table and then as random add, raise, check and accept
// episodes mixed with noise, across several register settings. Each response
// is compared field by field with a typed answer or a cycle-free table model.
// ----------------------------------------------------------------------------
module tb_top;
   import pic_pkg::*;

   localparam int MAX_SOURCES    = 32;
   localparam int PRIORITY_WORDS = 8;
   localparam int DIR_ROWS       = 24;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_REQUESTS = 116;
   localparam int REPORT_LINES   = 40;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      func_type                func;
      logic [SOURCE_ID_W-1:0]  id;
      logic [SLOT_W-1:0]       slot;
      logic [LEVEL_W-1:0]      level;
      logic                    pin;
      logic [LEVEL_W-1:0]      mask;
   } request_type;

   typedef struct packed {
      logic [SOURCE_ID_W-1:0]  source;
      logic [LEVEL_W-1:0]      level;
      logic [LEVEL_W-1:0]      new_mask;
      status_type              status;
   } answer_type;

   typedef struct packed {
      request_type  req;
      logic         typed;
      answer_type   answer;
   } dir_row_type;

   // typed flag low: take the answer from the table model
   localparam logic [26:0] PREDICTED = '0;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [1:0]             req_func;
   logic [SOURCE_ID_W-1:0] req_source_id;
   logic [SLOT_W-1:0]      req_slot;
   logic [LEVEL_W-1:0]     req_level;
   logic                   req_nmi_pin;
   logic [LEVEL_W-1:0]     req_cpu_mask;
   logic                   rsp_valid;
   logic [SOURCE_ID_W-1:0] rsp_chosen_source;
   logic [LEVEL_W-1:0]     rsp_chosen_level;
   logic [LEVEL_W-1:0]     rsp_new_mask;
   logic [1:0]             rsp_status;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [WORD_W-1:0]      csr_wdata;

   // table model state and registers
   logic [SOURCE_ID_W-1:0] src_id      [MAX_SOURCES];
   logic [SLOT_W-1:0]      src_slot    [MAX_SOURCES];
   logic                   src_pending [MAX_SOURCES];
   int                     src_count;
   logic [WORD_W-1:0]      prio_word   [PRIORITY_WORDS];
   logic                   nmi_last;
   logic [LEVEL_W-1:0]     held_level;
   logic                   cfg_rising;
   logic [SOURCE_ID_W-1:0] cfg_vector;
   logic [SOURCE_ID_W-1:0] cfg_min_id;

   answer_type             answers_due [$];
   dir_row_type            dir_tab [DIR_ROWS];
   logic [SOURCE_ID_W-1:0] last_pick;
   logic                   pin_level;
   int                     requests_sent;
   int                     mismatches;
   int                     idle_pct;

   priority_interrupt_controller_core #(
      .MAX_SOURCES    (MAX_SOURCES),
      .PRIORITY_WORDS (PRIORITY_WORDS)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_source_id     (req_source_id),
      .req_slot          (req_slot),
      .req_level         (req_level),
      .req_nmi_pin       (req_nmi_pin),
      .req_cpu_mask      (req_cpu_mask),
      .rsp_valid         (rsp_valid),
      .rsp_chosen_source (rsp_chosen_source),
      .rsp_chosen_level  (rsp_chosen_level),
      .rsp_new_mask      (rsp_new_mask),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      mismatches++;
      if (mismatches <= REPORT_LINES) begin
         $display("ERROR %0t ns: %s got %0h want %0h", $time, what, got, want);
      end
   endtask

   function automatic int find_source(input logic [SOURCE_ID_W-1:0] id);
      int i;
      for (i = 0; i < src_count; i++) begin
         if (src_id[i] == id) return i;
      end
      return -1;
   endfunction

   // Apply one request to the table model and return the answer it gives.
   function automatic answer_type pic_answer(input request_type r);
      answer_type       a;
      int               k;
      int               i;
      int               sh;
      logic             nmi_fired;
      logic             found;
      logic [LEVEL_W-1:0] best;
      logic [LEVEL_W-1:0] p;
      a = '0;
      a.status = STATUS_OK;
      case (r.func)
         FUNC_ADD: begin
            if (r.id < cfg_min_id || int'(r.slot[4:2]) >= PRIORITY_WORDS) begin
               a.status = STATUS_NOT_FOUND;
            end else if (find_source(r.id) >= 0) begin
               a.status = STATUS_DUPLICATE;
            end else if (src_count >= MAX_SOURCES) begin
               a.status = STATUS_FULL;
            end else begin
               src_id[src_count]      = r.id;
               src_slot[src_count]    = r.slot;
               src_pending[src_count] = 1'b0;
               src_count++;
               // lowest slot of a word sits in the top nibble
               sh = (3 - int'(r.slot[1:0])) * 4;
               prio_word[r.slot[4:2]][sh +: 4] = r.level;
            end
         end
         FUNC_RAISE: begin
            k = find_source(r.id);
            if (k < 0) a.status = STATUS_NOT_FOUND;
            else src_pending[k] = 1'b1;
         end
         FUNC_CHECK: begin
            nmi_fired = cfg_rising ? (!nmi_last && r.pin) : (nmi_last && !r.pin);
            nmi_last  = r.pin;
            if (nmi_fired) begin
               held_level = LEVEL_TOP;
               a.source   = cfg_vector;
            end else begin
               best  = '0;
               found = 1'b0;
               for (i = 0; i < src_count; i++) begin
                  if (src_pending[i]) begin
                     sh = (3 - int'(src_slot[i][1:0])) * 4;
                     p  = prio_word[src_slot[i][4:2]][sh +: 4];
                     // strictly greater: earliest entry keeps a tie
                     if ((p > best || !found) && p > r.mask) begin
                        best     = p;
                        a.source = src_id[i];
                        found    = 1'b1;
                     end
                  end
               end
               held_level = best;
            end
            last_pick = a.source;
         end
         default: begin
            a.new_mask = held_level;
            held_level = '0;
            k = find_source(r.id);
            if (k < 0) a.status = STATUS_NOT_FOUND;
            else src_pending[k] = 1'b0;
         end
      endcase
      a.level = held_level;
      return a;
   endfunction

   function automatic logic [SOURCE_ID_W-1:0] pick_id(input int known_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (src_count > 0 && roll < known_pct) return src_id[$urandom_range(0, src_count - 1)];
      if (roll < known_pct + 10) return cfg_min_id - 16'($urandom_range(0, 1));
      if (roll < known_pct + 15) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      return 16'($urandom);
   endfunction

   function automatic request_type noise_request();
      request_type r;
      r.func  = func_type'($urandom_range(0, 3));
      r.id    = 16'($urandom);
      r.slot  = 5'($urandom);
      r.level = 4'($urandom);
      r.pin   = 1'($urandom);
      r.mask  = 4'($urandom);
      return r;
   endfunction

   // Hold start low for a random gap, present the request and wait for it to
   // be taken; start stays high for a back-to-back follower.
   task automatic issue(input request_type r, input logic typed, input answer_type given);
      int         gap;
      answer_type want;
      gap = 0;
      while ($urandom_range(0, 99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_func      <= r.func;
      req_source_id <= r.id;
      req_slot      <= r.slot;
      req_level     <= r.level;
      req_nmi_pin   <= r.pin;
      req_cpu_mask  <= r.mask;
      do @(posedge clock); while (busy !== 1'b0);
      want = pic_answer(r);
      answers_due.push_back(typed ? given : want);
      requests_sent++;
   endtask

   task automatic drain_answers();
      start <= 1'b0;
      do @(posedge clock); while (answers_due.size() != 0);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [WORD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (index)
         CSR_NMI_RISING_EDGE: cfg_rising = value[0];
         CSR_NMI_VECTOR:      cfg_vector = value;
         CSR_MIN_SOURCE_ID:   cfg_min_id = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic rising, input logic [15:0] vector,
                            input logic [15:0] min_id, input logic poke_unused);
      logic [WORD_W-1:0] edge_word;
      drain_answers();
      repeat (MAX_SOURCES + 4) @(posedge clock);
      // only bit 0 counts; fill the rest with junk
      edge_word    = 16'($urandom);
      edge_word[0] = rising;
      write_register(CSR_NMI_RISING_EDGE, edge_word);
      write_register(CSR_NMI_VECTOR, vector);
      write_register(CSR_MIN_SOURCE_ID, min_id);
      if (poke_unused) write_register(CSR_UNUSED, 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Mostly add / raise / check / accept episodes, the rest noise.
   task automatic run_random(input int until_count);
      request_type r;
      int          n;
      while (requests_sent < until_count) begin
         if ($urandom_range(0, 99) < 4) drain_answers();
         r = noise_request();
         if ($urandom_range(0, 99) < 25) begin
            issue(r, 1'b0, '0);
         end else begin
            if ($urandom_range(0, 1) != 0) begin
               r.func = FUNC_ADD;
               r.id   = pick_id(20);
               issue(r, 1'b0, '0);
               r = noise_request();
            end
            n = $urandom_range(0, 3);
            repeat (n) begin
               r.func = FUNC_RAISE;
               r.id   = pick_id(70);
               issue(r, 1'b0, '0);
               r = noise_request();
            end
            if ($urandom_range(0, 2) == 0) pin_level = !pin_level;
            r.func = FUNC_CHECK;
            r.pin  = pin_level;
            r.mask = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'($urandom_range(0, 6));
            issue(r, 1'b0, '0);
            r      = noise_request();
            r.func = FUNC_ACCEPT;
            r.id   = ($urandom_range(0, 4) != 0) ? last_pick : pick_id(70);
            issue(r, 1'b0, '0);
         end
      end
   endtask

   always @(posedge clock) begin : check_answers
      answer_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (answers_due.size() == 0) begin
            report_mismatch("response with no request waiting", rsp_chosen_source, 16'h0);
         end else begin
            want = answers_due.pop_front();
            if (rsp_chosen_source !== want.source)
               report_mismatch("chosen_source", rsp_chosen_source, want.source);
            if (rsp_chosen_level !== want.level)
               report_mismatch("chosen_level", 16'(rsp_chosen_level), 16'(want.level));
            if (rsp_new_mask !== want.new_mask)
               report_mismatch("new_mask", 16'(rsp_new_mask), 16'(want.new_mask));
            if (rsp_status !== want.status)
               report_mismatch("status", 16'(rsp_status), 16'(want.status));
         end
      end
   end

   initial begin
      int row;
      int phase;
      int wait_cycles;

      reset         = 1'b1;
      start         = 1'b0;
      req_func      = FUNC_ADD;
      req_source_id = '0;
      req_slot      = '0;
      req_level     = '0;
      req_nmi_pin   = 1'b0;
      req_cpu_mask  = '0;
      csr_valid     = 1'b0;
      csr_index     = CSR_NMI_RISING_EDGE;
      csr_wdata     = '0;

      for (row = 0; row < MAX_SOURCES; row++) src_pending[row] = 1'b0;
      for (row = 0; row < PRIORITY_WORDS; row++) prio_word[row] = '0;
      src_count     = 0;
      nmi_last      = 1'b0;
      held_level    = '0;
      cfg_rising    = 1'b0;
      cfg_vector    = NMI_VECTOR_RESET;
      cfg_min_id    = '0;
      last_pick     = '0;
      pin_level     = 1'b0;
      requests_sent = 0;
      mismatches    = 0;
      idle_pct      = 25;

      //            func         id        slot   lvl   pin   mask  expected
      dir_tab[0]  = {FUNC_CHECK,  16'h0000, 5'd0,  4'h0, 1'b0, 4'h0,
                     1'b1, 16'h0000, 4'h0, 4'h0, STATUS_OK};
      dir_tab[1]  = {FUNC_ACCEPT, 16'h0005, 5'd0,  4'h0, 1'b0, 4'h0,
                     1'b1, 16'h0000, 4'h0, 4'h0, STATUS_NOT_FOUND};
      dir_tab[2]  = {FUNC_RAISE,  16'hFFFF, 5'd31, 4'hF, 1'b0, 4'hF,
                     1'b1, 16'h0000, 4'h0, 4'h0, STATUS_NOT_FOUND};
      dir_tab[3]  = {FUNC_ADD,    16'h0000, 5'd0,  4'hF, 1'b0, 4'h0,
                     1'b1, 16'h0000, 4'h0, 4'h0, STATUS_OK};
      dir_tab[4]  = {FUNC_ADD,    16'hFFFF, 5'd31, 4'h1, 1'b1, 4'hF,
                     1'b1, 16'h0000, 4'h0, 4'h0, STATUS_OK};
      dir_tab[5]  = {FUNC_ADD,    16'h0000, 5'd3,  4'h2, 1'b0, 4'h0,
                     1'b1, 16'h0000, 4'h0, 4'h0, STATUS_DUPLICATE};
      dir_tab[6]  = {FUNC_ADD,    16'h1234, 5'd5,  4'h7, 1'b0, 4'h0, PREDICTED};
      dir_tab[7]  = {FUNC_RAISE,  16'h0000, 5'd0,  4'h0, 1'b0, 4'h0, PREDICTED};
      dir_tab[8]  = {FUNC_RAISE,  16'h0000, 5'd0,  4'h0, 1'b0, 4'h0, PREDICTED};
      dir_tab[9]  = {FUNC_RAISE,  16'hFFFF, 5'd0,  4'h0, 1'b0, 4'h0, PREDICTED};
      dir_tab[10] = {FUNC_CHECK,  16'h0000, 5'd0,  4'h0, 1'b1, 4'h0, PREDICTED};
      dir_tab[11] = {FUNC_ACCEPT, 16'h0000, 5'd0,  4'h0, 1'b0, 4'h0, PREDICTED};
      dir_tab[12] = {FUNC_CHECK,  16'h0000, 5'd0,  4'h0, 1'b0, 4'h0,
                     1'b1, NMI_VECTOR_RESET, LEVEL_TOP, 4'h0, STATUS_OK};
      dir_tab[13] = {FUNC_ACCEPT, 16'h1234, 5'd0,  4'h0, 1'b0, 4'h0, PREDICTED};
      dir_tab[14] = {FUNC_CHECK,  16'h0000, 5'd0,  4'h0, 1'b0, 4'hF,
                     1'b1, 16'h0000, 4'h0, 4'h0, STATUS_OK};
      dir_tab[15] = {FUNC_CHECK,  16'h0000, 5'd0,  4'h0, 1'b0, 4'h0, PREDICTED};
      dir_tab[16] = {FUNC_RAISE,  16'h1234, 5'd0,  4'h0, 1'b0, 4'h0, PREDICTED};
      dir_tab[17] = {FUNC_ADD,    16'h0042, 5'd5,  4'h9, 1'b0, 4'h0, PREDICTED};
      dir_tab[18] = {FUNC_RAISE,  16'h0042, 5'd0,  4'h0, 1'b0, 4'h0, PREDICTED};
      dir_tab[19] = {FUNC_CHECK,  16'h0000, 5'd0,  4'h0, 1'b1, 4'h8, PREDICTED};
      dir_tab[20] = {FUNC_CHECK,  16'h0000, 5'd0,  4'h0, 1'b1, 4'h9, PREDICTED};
      dir_tab[21] = {FUNC_RAISE,  16'h0000, 5'd0,  4'h0, 1'b0, 4'h0, PREDICTED};
      dir_tab[22] = {FUNC_CHECK,  16'h0000, 5'd0,  4'h0, 1'b1, 4'hE, PREDICTED};
      dir_tab[23] = {FUNC_ACCEPT, 16'h0000, 5'd0,  4'h0, 1'b0, 4'h0, PREDICTED};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIR_ROWS; row++) begin
         issue(dir_tab[row].req, dir_tab[row].typed, dir_tab[row].answer);
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               idle_pct = 25;
               configure(1'b1, 16'hFFFF, 16'h0100, 1'b0);
            end
            1: begin
               idle_pct = 25;
               configure(1'b0, 16'h0000, 16'h0000, 1'b0);
            end
            2: begin
               idle_pct = 83;
               configure(1'b1, 16'($urandom), 16'($urandom_range(0, 16'h7FFF)), 1'b0);
            end
            3: begin
               idle_pct = 83;
               configure(1'b0, 16'($urandom), 16'hFFFF, 1'b1);
            end
            4: begin
               idle_pct = 0;
               configure(1'b1, 16'($urandom), 16'h0000, 1'b0);
            end
            default: begin
               idle_pct = 0;
               configure(1'b0, NMI_VECTOR_RESET, 16'($urandom), 1'b0);
            end
         endcase
         run_random(DIR_ROWS + PHASE_REQUESTS * (phase + 1));
      end

      start <= 1'b0;
      wait_cycles = 0;
      while (answers_due.size() != 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (MAX_SOURCES + 8) @(posedge clock);
      if (answers_due.size() != 0)
         report_mismatch("requests left without response", 16'(answers_due.size()), 16'h0);

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
